[sv/phta_pkg.sv]
// Package for the per-host traffic accounting unit.
// Holds table geometry, opcodes, status codes and the table entry type.
package phta_pkg;

  localparam int MaxHosts = 64;
  localparam int SlotW = $clog2(MaxHosts);
  localparam int CountW = $clog2(MaxHosts + 1);

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [15:0] ETH_V4 = 16'h0800;
  localparam logic [15:0] ETH_V6 = 16'h86DD;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_COUNTED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;
  localparam logic [2:0] ST_READ = 3'd5;
  localparam logic [2:0] ST_EMPTY = 3'd6;

  localparam logic [2:0] CFG_V4_ADDR = 3'd0;
  localparam logic [2:0] CFG_V4_MASK = 3'd1;
  localparam logic [2:0] CFG_V6_HIGH = 3'd2;
  localparam logic [2:0] CFG_V6_LOW = 3'd3;
  localparam logic [2:0] CFG_V6_PLEN = 3'd4;
  localparam logic [2:0] CFG_V4_EN = 3'd5;
  localparam logic [2:0] CFG_V6_EN = 3'd6;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] pass_rx;
    logic [31:0] pass_tx;
    logic [63:0] total_rx;
    logic [63:0] total_tx;
    logic [31:0] last_active;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

[sv/phta_if.sv]
// Valid/ready channel interfaces for the accounting unit.
// Imports phta_pkg; the slot and count widths are written as literal widths.
interface phta_in_if import phta_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] ethertype;
  logic [63:0] src_high;
  logic [63:0] src_low;
  logic [63:0] dst_high;
  logic [63:0] dst_low;
  logic [47:0] src_mac;
  logic [47:0] dst_mac;
  logic [15:0] frame_len;
  logic [31:0] now_time;
  logic [5:0]  entry_index;
  modport source (output valid, opcode, ethertype, src_high, src_low, dst_high, dst_low,
                  src_mac, dst_mac, frame_len, now_time, entry_index, input ready);
  modport sink (input valid, opcode, ethertype, src_high, src_low, dst_high, dst_low,
                src_mac, dst_mac, frame_len, now_time, entry_index, output ready);
endinterface

interface phta_out_if import phta_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  src_slot;
  logic [6:0]  dst_slot;
  logic [31:0] entry_ip;
  logic [47:0] entry_mac;
  logic [31:0] pass_rx;
  logic [31:0] pass_tx;
  logic [63:0] total_rx;
  logic [63:0] total_tx;
  logic [31:0] last_active;
  logic [6:0]  entry_count;
  modport source (output valid, status, src_slot, dst_slot, entry_ip, entry_mac, pass_rx,
                  pass_tx, total_rx, total_tx, last_active, entry_count, input ready);
  modport sink (input valid, status, src_slot, dst_slot, entry_ip, entry_mac, pass_rx,
                pass_tx, total_rx, total_tx, last_active, entry_count, output ready);
endinterface

[sv/phta_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module phta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/per_host_traffic_accounting_unit.sv]
// Per-host traffic accounting unit: one item in, one result out, one item in work at a time.
// A frame searches the table for each matching side one slot at a time, then writes the
// entry back. A pass clear zeroes the pass counters below the count, a read returns one
// entry, an unused opcode is answered as ignored; the next item is taken once the result
// is taken. Synchronous active-low reset clears the configuration, state, output valid and
// host count; the table memory is not cleared, since only slots below the count are read.
module per_host_traffic_accounting_unit import phta_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  phta_in_if.sink       in_ch,
  phta_out_if.source    out_ch
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SIDE   = 4'd1;
  localparam logic [3:0] S_SRCH   = 4'd2;
  localparam logic [3:0] S_SWAIT  = 4'd3;
  localparam logic [3:0] S_CHARGE = 4'd4;
  localparam logic [3:0] S_CLR    = 4'd5;
  localparam logic [3:0] S_CLRW   = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_RDW    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_RMW    = 4'd10;

  logic [31:0] v4_addr_r, v4_mask_r;
  logic [63:0] v6_high_r, v6_low_r;
  logic [7:0]  v6_plen_r;
  logic        v4_en_r, v6_en_r;

  logic [3:0]  state_r;
  logic [CountW-1:0] count_r;
  logic [CountW-1:0] scan_r;
  logic        side_r;
  logic        is_v6_r;
  logic [15:0] len_r;
  logic [31:0] now_r;
  logic [31:0] sip_r, dip_r;
  logic [47:0] smac_r, dmac_r;
  logic        s_match_r, d_match_r;
  logic [SlotW-1:0] idx_r;
  logic        full_r, any_r, unknown_r;
  logic [6:0]  ss_r, ds_r;
  logic [SlotW-1:0] slot_r;
  logic        fresh_r;

  logic        we;
  logic [SlotW-1:0] addr;
  entry_t      wdata, rdata, mod;

  phta_ram #(.Width(EntryW), .Depth(MaxHosts)) u_table (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  function automatic logic v4_hit(input logic [31:0] a, input logic [31:0] na,
                                  input logic [31:0] nm, input logic en);
    v4_hit = en && ((a & nm) == (na & nm));
  endfunction

  logic [127:0] v6_mask;
  logic [7:0]   plen;
  always_comb begin
    plen = (v6_plen_r > 8'd128) ? 8'd128 : v6_plen_r;
    v6_mask = (plen == 8'd0) ? '0 : ~(128'h0) << (8'd128 - plen);
  end

  logic s4, d4, s6, d6;
  assign s4 = v4_hit(in_ch.src_low[31:0], v4_addr_r, v4_mask_r, v4_en_r);
  assign d4 = v4_hit(in_ch.dst_low[31:0], v4_addr_r, v4_mask_r, v4_en_r);
  assign s6 = v6_en_r && ((({in_ch.src_high, in_ch.src_low} ^ {v6_high_r, v6_low_r})
                          & v6_mask) == '0);
  assign d6 = v6_en_r && ((({in_ch.dst_high, in_ch.dst_low} ^ {v6_high_r, v6_low_r})
                          & v6_mask) == '0);

  logic [31:0] cur_ip;
  logic [47:0] cur_mac;
  logic        cur_match;
  assign cur_ip = side_r ? dip_r : sip_r;
  assign cur_mac = side_r ? dmac_r : smac_r;
  assign cur_match = side_r ? d_match_r : s_match_r;

  logic [32:0] sum32;
  always_comb begin
    mod = rdata;
    if (fresh_r) begin
      mod = '0;
      mod.ip = cur_ip;
      mod.mac = cur_mac;
    end
    if (!side_r) begin
      sum32 = {1'b0, mod.pass_tx} + {17'd0, len_r};
      mod.pass_tx = sum32[32] ? '1 : sum32[31:0];
      mod.total_tx = mod.total_tx + {48'd0, len_r};
    end else begin
      sum32 = {1'b0, mod.pass_rx} + {17'd0, len_r};
      mod.pass_rx = sum32[32] ? '1 : sum32[31:0];
      mod.total_rx = mod.total_rx + {48'd0, len_r};
    end
    mod.last_active = now_r;
  end

  logic hit;
  assign hit = is_v6_r ? (rdata.mac == cur_mac) : (rdata.ip == cur_ip);

  always_comb begin
    we = 1'b0;
    addr = scan_r[SlotW-1:0];
    wdata = mod;
    unique case (state_r)
      S_CHARGE: begin
        we = 1'b1;
        addr = slot_r;
      end
      S_RD, S_RDW: addr = idx_r;
      S_CLRW: begin
        we = 1'b1;
        addr = slot_r;
        wdata = rdata;
        wdata.pass_rx = '0;
        wdata.pass_tx = '0;
      end
      default: ;
    endcase
  end

  logic [2:0]  st_nxt;
  assign in_ch.ready = (state_r == S_IDLE) && !out_ch.valid;

  logic out_valid_r;
  logic [2:0] o_status_r;
  entry_t o_entry_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = o_status_r;
  assign out_ch.src_slot = ss_r;
  assign out_ch.dst_slot = ds_r;
  assign out_ch.entry_ip = o_entry_r.ip;
  assign out_ch.entry_mac = o_entry_r.mac;
  assign out_ch.pass_rx = o_entry_r.pass_rx;
  assign out_ch.pass_tx = o_entry_r.pass_tx;
  assign out_ch.total_rx = o_entry_r.total_rx;
  assign out_ch.total_tx = o_entry_r.total_tx;
  assign out_ch.last_active = o_entry_r.last_active;
  assign out_ch.entry_count = 7'(count_r);

  always_comb begin
    st_nxt = unknown_r ? ST_UNKNOWN : full_r ? ST_FULL : any_r ? ST_COUNTED : ST_IGNORED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_addr_r <= '0; v4_mask_r <= '0; v6_high_r <= '0; v6_low_r <= '0;
      v6_plen_r <= '0; v4_en_r <= 1'b0; v6_en_r <= 1'b0;
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_V4_ADDR: v4_addr_r <= cfg_data[31:0];
          CFG_V4_MASK: v4_mask_r <= cfg_data[31:0];
          CFG_V6_HIGH: v6_high_r <= cfg_data;
          CFG_V6_LOW:  v6_low_r <= cfg_data;
          CFG_V6_PLEN: v6_plen_r <= cfg_data[7:0];
          CFG_V4_EN:   v4_en_r <= cfg_data[0];
          CFG_V6_EN:   v6_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            len_r <= in_ch.frame_len;
            now_r <= in_ch.now_time;
            sip_r <= in_ch.src_low[31:0];
            dip_r <= in_ch.dst_low[31:0];
            smac_r <= in_ch.src_mac;
            dmac_r <= in_ch.dst_mac;
            idx_r <= in_ch.entry_index[SlotW-1:0];
            is_v6_r <= (in_ch.ethertype == ETH_V6);
            full_r <= 1'b0; any_r <= 1'b0; unknown_r <= 1'b0;
            ss_r <= 7'(MaxHosts); ds_r <= 7'(MaxHosts);
            o_entry_r <= '0;
            side_r <= 1'b0;
            scan_r <= '0;
            unique case (in_ch.opcode)
              OP_FRAME: begin
                s_match_r <= (in_ch.ethertype == ETH_V4) ? s4 :
                             (in_ch.ethertype == ETH_V6) ? s6 : 1'b0;
                d_match_r <= (in_ch.ethertype == ETH_V4) ? d4 :
                             (in_ch.ethertype == ETH_V6) ? d6 : 1'b0;
                state_r <= S_SIDE;
              end
              OP_CLEAR: state_r <= S_CLR;
              OP_READ: state_r <= S_RD;
              default: begin
                o_status_r <= ST_IGNORED;
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_SIDE: begin
          scan_r <= '0;
          if (unknown_r) begin
            state_r <= S_DONE;
          end else if (!cur_match) begin
            if (side_r) state_r <= S_DONE;
            else side_r <= 1'b1;
          end else begin
            any_r <= 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (scan_r >= count_r) begin
            if (is_v6_r) begin
              unknown_r <= 1'b1;
              state_r <= S_DONE;
            end else if (count_r >= CountW'(MaxHosts)) begin
              full_r <= 1'b1;
              state_r <= side_r ? S_DONE : S_SIDE;
              side_r <= 1'b1;
            end else begin
              slot_r <= count_r[SlotW-1:0];
              fresh_r <= 1'b1;
              count_r <= count_r + 1'b1;
              state_r <= S_RMW;
            end
          end else begin
            state_r <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (hit) begin
            slot_r <= scan_r[SlotW-1:0];
            fresh_r <= 1'b0;
            state_r <= S_CHARGE;
          end else begin
            scan_r <= scan_r + 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_RMW: state_r <= S_CHARGE;
        S_CHARGE: begin
          if (side_r) ds_r <= 7'(slot_r);
          else ss_r <= 7'(slot_r);
          state_r <= side_r ? S_DONE : S_SIDE;
          side_r <= 1'b1;
        end
        S_DONE: begin
          o_status_r <= st_nxt;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_CLR: begin
          if (scan_r >= count_r) begin
            o_status_r <= ST_CLEARED;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            slot_r <= scan_r[SlotW-1:0];
            scan_r <= scan_r + 1'b1;
            state_r <= S_CLRW;
          end
        end
        S_CLRW: state_r <= S_CLR;
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          if (CountW'(idx_r) < count_r) begin
            o_status_r <= ST_READ;
            o_entry_r <= rdata;
          end else begin
            o_status_r <= ST_EMPTY;
          end
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
